>>> hw/rtl/cpts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpts_pkg
// Shared types, codes and constants of the periodic CAN transmit scheduler.
// ----------------------------------------------------------------------------
package cpts_pkg;

	localparam int MAX_JOBS_DEF    = 32;
	localparam int BURST_LIMIT_DEF = 16;
	localparam int SLEEP_CAP_DEF   = 50;
	localparam int QUEUE_DEPTH     = 2;

	localparam int TIME_W  = 48;
	localparam int PER_W   = 32;
	localparam int ID_W    = 31;
	localparam int IDENT_W = 29;
	localparam int LEN_W   = 4;
	localparam int PAY_W   = 64;
	localparam int SLEEP_W = 6;
	localparam int FLAGS_W = IDENT_W + 2 + LEN_W;

	localparam logic [1:0] CMD_SCAN     = 2'd0;
	localparam logic [1:0] CMD_REGISTER = 2'd1;
	localparam logic [1:0] CMD_CANCEL   = 2'd2;
	localparam logic [1:0] CMD_UNUSED   = 2'd3;

	localparam logic [1:0] KIND_FRAME      = 2'd0;
	localparam logic [1:0] KIND_SUMMARY    = 2'd1;
	localparam logic [1:0] KIND_REG_ACK    = 2'd2;
	localparam logic [1:0] KIND_CANCEL_ACK = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_INVALID = 2'd1;
	localparam logic [1:0] STAT_FULL    = 2'd2;

	localparam logic [LEN_W-1:0] MAX_DLC = 4'd8;

	typedef enum logic [1:0] {
		OP_SCAN,
		OP_REGISTER,
		OP_CANCEL
	} op_t;

	typedef struct packed {
		op_t                 op;
		logic [TIME_W-1:0]   now;
		logic [ID_W-1:0]     cancel_id;
		logic [IDENT_W-1:0]  ident;
		logic                ext;
		logic                rtr;
		logic [LEN_W-1:0]    len;
		logic [PAY_W-1:0]    payload;
		logic [PER_W-1:0]    period;
	} job_cmd_t;

	typedef enum logic [3:0] {
		ES_IDLE,
		ES_REG,
		ES_C_FIND,
		ES_C_CMP,
		ES_C_DONE,
		ES_S_FIND,
		ES_S_EVAL,
		ES_S_EMIT,
		ES_S_DIV,
		ES_S_UPD,
		ES_S_SUM
	} eng_state_t;

endpackage

>>> hw/rtl/cpts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpts_front
// Accepts command items, drops unused codes and queues the rest for the engine.
// ----------------------------------------------------------------------------
module cpts_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        cmd,
	input  logic [cpts_pkg::TIME_W-1:0]       current_time_ms,
	input  logic [cpts_pkg::ID_W-1:0]         cancel_id,
	input  logic [cpts_pkg::IDENT_W-1:0]      frame_ident,
	input  logic                              frame_extended,
	input  logic                              frame_remote,
	input  logic [cpts_pkg::LEN_W-1:0]        frame_length,
	input  logic [cpts_pkg::PAY_W-1:0]        frame_payload,
	input  logic [cpts_pkg::PER_W-1:0]        period,
	output logic                              q_valid,
	output cpts_pkg::job_cmd_t                q_head,
	input  logic                              q_pop
);
	import cpts_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_cmd_t          ent_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              accept;
	logic              push;
	job_cmd_t          item;

	assign in_ready = (cnt_q != CNT_W'(QUEUE_DEPTH));
	assign accept   = in_valid && in_ready;
	assign push     = accept && (cmd != CMD_UNUSED);
	assign q_valid  = (cnt_q != '0);
	assign q_head   = ent_q[rd_ptr_q];

	always_comb begin
		item.now       = current_time_ms;
		item.cancel_id = cancel_id;
		item.ident     = frame_ident;
		item.ext       = frame_extended;
		item.rtr       = frame_remote;
		item.len       = frame_length;
		item.payload   = frame_payload;
		item.period    = period;
		unique case (cmd)
			CMD_REGISTER: item.op = OP_REGISTER;
			CMD_CANCEL:   item.op = OP_CANCEL;
			default:      item.op = OP_SCAN;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(q_pop);
		end
	end

endmodule

>>> hw/rtl/cpts_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpts_div
// Restoring divider, one dividend bit per cycle, returns the remainder only.
// ----------------------------------------------------------------------------
module cpts_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cpts_pkg::TIME_W-1:0]   dividend,
	input  logic [cpts_pkg::PER_W-1:0]    divisor,
	output logic                          busy,
	output logic [cpts_pkg::PER_W-1:0]    remainder
);
	import cpts_pkg::*;

	localparam int CNT_W = $clog2(TIME_W + 1);

	logic [PER_W-1:0]  rem_q;
	logic [TIME_W-1:0] dvd_q;
	logic [PER_W-1:0]  dsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [PER_W:0]    trial;
	logic [PER_W:0]    rem_next;

	always_comb begin
		trial    = {rem_q, dvd_q[TIME_W-1]};
		rem_next = (trial >= {1'b0, dsr_q}) ? trial - {1'b0, dsr_q} : trial;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next[PER_W-1:0];
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(TIME_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q;

endmodule

>>> hw/rtl/cpts_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpts_engine
// Job table and command sequencer: register, cancel and scan with an output
// register toward the result channel.
// ----------------------------------------------------------------------------
module cpts_engine #(
	parameter int MAX_JOBS     = cpts_pkg::MAX_JOBS_DEF,
	parameter int BURST_LIMIT  = cpts_pkg::BURST_LIMIT_DEF,
	parameter int SLEEP_CAP_MS = cpts_pkg::SLEEP_CAP_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	input  cpts_pkg::job_cmd_t             q_head,
	output logic                           q_pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     kind,
	output logic [1:0]                     status,
	output logic [cpts_pkg::ID_W-1:0]      assigned_id,
	output logic [cpts_pkg::IDENT_W-1:0]   tx_ident,
	output logic                           tx_extended,
	output logic                           tx_remote,
	output logic [cpts_pkg::LEN_W-1:0]     tx_length,
	output logic [cpts_pkg::PAY_W-1:0]     tx_payload,
	output logic [cpts_pkg::SLEEP_W-1:0]   sleep_hint,
	output logic                           overflow,
	output logic                           last
);
	import cpts_pkg::*;

	localparam int AW    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int AGE_W = $clog2(MAX_JOBS + 1);
	localparam int NP_W  = $clog2(BURST_LIMIT + 1);
	localparam int EXT_W = TIME_W - PER_W + 1;

	function automatic logic [PAY_W-1:0] frame_data(input logic rtr,
		input logic [LEN_W-1:0] dlc, input logic [PAY_W-1:0] d);
		logic [PAY_W-1:0] m;
		m = '0;
		for (int b = 0; b < PAY_W / 8; b++) begin
			if (LEN_W'(b) < dlc) begin
				m[b*8 +: 8] = 8'hff;
			end
		end
		return rtr ? '0 : (d & m);
	endfunction

	// job table
	logic [ID_W-1:0]    mem_id    [MAX_JOBS];
	logic [FLAGS_W-1:0] mem_flags [MAX_JOBS];
	logic [PAY_W-1:0]   mem_pay   [MAX_JOBS];
	logic [PER_W-1:0]   mem_per   [MAX_JOBS];
	logic [TIME_W-1:0]  mem_due   [MAX_JOBS];

	logic [ID_W-1:0]    rd_id;
	logic [FLAGS_W-1:0] rd_flags;
	logic [PAY_W-1:0]   rd_pay;
	logic [PER_W-1:0]   rd_per;
	logic [TIME_W-1:0]  rd_due;

	logic [MAX_JOBS-1:0] valid_q;
	logic [AGE_W-1:0]    ord_q [MAX_JOBS];
	logic [ID_W-1:0]     id_q;

	eng_state_t          state_q, state_d;
	job_cmd_t            cur_q;
	logic [AGE_W-1:0]    age_q, age_d;
	logic [AW-1:0]       slot_q, slot_d;
	logic [1:0]          stat_q, stat_d;
	logic [NP_W-1:0]     np_q, np_d;
	logic                ovf_q, ovf_d;
	logic [TIME_W-1:0]   sleep_q, sleep_d;

	logic                out_valid_q;
	logic [1:0]          kind_q, status_q;
	logic [ID_W-1:0]     aid_q;
	logic [IDENT_W-1:0]  txid_q;
	logic                txext_q, txrtr_q, ovf_out_q, last_q;
	logic [LEN_W-1:0]    txlen_q;
	logic [PAY_W-1:0]    txpay_q;
	logic [SLEEP_W-1:0]  hint_q;

	logic                out_free, out_load;
	logic [1:0]          o_kind, o_status;
	logic [ID_W-1:0]     o_aid;
	logic [IDENT_W-1:0]  o_txid;
	logic                o_txext, o_txrtr, o_ovf, o_last;
	logic [LEN_W-1:0]    o_txlen;
	logic [PAY_W-1:0]    o_txpay;
	logic [SLEEP_W-1:0]  o_hint;

	logic [MAX_JOBS-1:0] match;
	logic                found;
	logic [AW-1:0]       hit_slot, free_slot;
	logic                full;
	logic [ID_W-1:0]     next_id, id_inc;
	logic                reg_commit, cancel_commit, rd_en, due_wr, div_start;
	logic                div_busy;
	logic [PER_W-1:0]    div_rem;
	logic [TIME_W:0]     reg_sum, upd_sum;
	logic [TIME_W-1:0]   reg_due, new_due, late, remain_ev, remain_up;
	logic                due_now;
	logic [LEN_W-1:0]    rd_len, clamp_len;

	always_comb begin
		hit_slot  = '0;
		free_slot = '0;
		for (int i = 0; i < MAX_JOBS; i++) begin
			match[i] = valid_q[i] && (ord_q[i] == age_q);
			if (match[i]) begin
				hit_slot = AW'(i);
			end
		end
		for (int i = MAX_JOBS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_slot = AW'(i);
			end
		end
	end

	assign found     = |match;
	assign full      = &valid_q;
	assign id_inc    = id_q + 1'b1;
	assign next_id   = (id_inc == '0) ? ID_W'(1) : id_inc;
	assign out_free  = !out_valid_q || out_ready;
	assign reg_sum   = {1'b0, cur_q.now} + {{EXT_W{1'b0}}, cur_q.period};
	assign reg_due   = reg_sum[TIME_W] ? '1 : reg_sum[TIME_W-1:0];
	assign due_now   = (cur_q.now >= rd_due);
	assign late      = cur_q.now - rd_due;
	assign remain_ev = rd_due - cur_q.now;
	assign upd_sum   = {1'b0, cur_q.now} - {{EXT_W{1'b0}}, div_rem}
		+ {{EXT_W{1'b0}}, rd_per};
	assign new_due   = upd_sum[TIME_W] ? '1 : upd_sum[TIME_W-1:0];
	assign remain_up = new_due - cur_q.now;
	assign rd_len    = rd_flags[FLAGS_W-1 -: LEN_W];
	assign clamp_len = (rd_len > MAX_DLC) ? MAX_DLC : rd_len;

	cpts_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (late),
		.divisor   (rd_per),
		.busy      (div_busy),
		.remainder (div_rem)
	);

	always_comb begin
		state_d       = state_q;
		age_d         = age_q;
		slot_d        = slot_q;
		stat_d        = stat_q;
		np_d          = np_q;
		ovf_d         = ovf_q;
		sleep_d       = sleep_q;
		q_pop         = 1'b0;
		out_load      = 1'b0;
		reg_commit    = 1'b0;
		cancel_commit = 1'b0;
		rd_en         = 1'b0;
		due_wr        = 1'b0;
		div_start     = 1'b0;
		o_kind        = KIND_FRAME;
		o_status      = STAT_OK;
		o_aid         = '0;
		o_txid        = '0;
		o_txext       = 1'b0;
		o_txrtr       = 1'b0;
		o_txlen       = '0;
		o_txpay       = '0;
		o_hint        = '0;
		o_ovf         = 1'b0;
		o_last        = 1'b0;
		unique case (state_q)
			ES_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					age_d   = '0;
					np_d    = '0;
					ovf_d   = 1'b0;
					sleep_d = TIME_W'(SLEEP_CAP_MS);
					stat_d  = STAT_INVALID;
					unique case (q_head.op)
						OP_REGISTER: state_d = ES_REG;
						OP_CANCEL:   state_d = (q_head.cancel_id == '0) ? ES_C_DONE : ES_C_FIND;
						default:     state_d = ES_S_FIND;
					endcase
				end
			end
			ES_REG: begin
				if (out_free) begin
					out_load = 1'b1;
					o_kind   = KIND_REG_ACK;
					o_last   = 1'b1;
					if (cur_q.period == '0) begin
						o_status = STAT_INVALID;
					end else if (full) begin
						o_status = STAT_FULL;
					end else begin
						reg_commit = 1'b1;
						o_aid      = next_id;
					end
					state_d = ES_IDLE;
				end
			end
			ES_C_FIND: begin
				if (found) begin
					rd_en   = 1'b1;
					slot_d  = hit_slot;
					state_d = ES_C_CMP;
				end else begin
					state_d = ES_C_DONE;
				end
			end
			ES_C_CMP: begin
				if (rd_id == cur_q.cancel_id) begin
					stat_d  = STAT_OK;
					state_d = ES_C_DONE;
				end else begin
					age_d   = age_q + 1'b1;
					state_d = ES_C_FIND;
				end
			end
			ES_C_DONE: begin
				if (out_free) begin
					out_load      = 1'b1;
					o_kind        = KIND_CANCEL_ACK;
					o_status      = stat_q;
					o_last        = 1'b1;
					cancel_commit = (stat_q == STAT_OK);
					state_d       = ES_IDLE;
				end
			end
			ES_S_FIND: begin
				if (found) begin
					rd_en   = 1'b1;
					slot_d  = hit_slot;
					state_d = ES_S_EVAL;
				end else begin
					state_d = ES_S_SUM;
				end
			end
			ES_S_EVAL: begin
				if (due_now) begin
					if (np_q < NP_W'(BURST_LIMIT)) begin
						state_d = ES_S_EMIT;
					end else begin
						ovf_d     = 1'b1;
						div_start = 1'b1;
						state_d   = ES_S_DIV;
					end
				end else begin
					if (remain_ev < sleep_q) begin
						sleep_d = remain_ev;
					end
					age_d   = age_q + 1'b1;
					state_d = ES_S_FIND;
				end
			end
			ES_S_EMIT: begin
				if (out_free) begin
					out_load  = 1'b1;
					o_kind    = KIND_FRAME;
					o_txid    = rd_flags[IDENT_W-1:0];
					o_txext   = rd_flags[IDENT_W];
					o_txrtr   = rd_flags[IDENT_W+1];
					o_txlen   = clamp_len;
					o_txpay   = frame_data(rd_flags[IDENT_W+1], clamp_len, rd_pay);
					np_d      = np_q + 1'b1;
					div_start = 1'b1;
					state_d   = ES_S_DIV;
				end
			end
			ES_S_DIV: begin
				if (!div_busy) begin
					state_d = ES_S_UPD;
				end
			end
			ES_S_UPD: begin
				due_wr = 1'b1;
				if (remain_up < sleep_q) begin
					sleep_d = remain_up;
				end
				age_d   = age_q + 1'b1;
				state_d = ES_S_FIND;
			end
			ES_S_SUM: begin
				if (out_free) begin
					out_load = 1'b1;
					o_kind   = KIND_SUMMARY;
					o_hint   = ovf_q ? '0 : sleep_q[SLEEP_W-1:0];
					o_ovf    = ovf_q;
					o_last   = 1'b1;
					state_d  = ES_IDLE;
				end
			end
			default: begin
				state_d = ES_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (reg_commit) begin
			mem_id[free_slot]    <= next_id;
			mem_flags[free_slot] <= {cur_q.len, cur_q.rtr, cur_q.ext, cur_q.ident};
			mem_pay[free_slot]   <= cur_q.payload;
			mem_per[free_slot]   <= cur_q.period;
		end
		if (reg_commit) begin
			mem_due[free_slot] <= reg_due;
		end else if (due_wr) begin
			mem_due[slot_q] <= new_due;
		end
		if (rd_en) begin
			rd_id    <= mem_id[hit_slot];
			rd_flags <= mem_flags[hit_slot];
			rd_pay   <= mem_pay[hit_slot];
			rd_per   <= mem_per[hit_slot];
			rd_due   <= mem_due[hit_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end
		age_q   <= age_d;
		slot_q  <= slot_d;
		stat_q  <= stat_d;
		np_q    <= np_d;
		ovf_q   <= ovf_d;
		sleep_q <= sleep_d;
		if (out_load) begin
			kind_q    <= o_kind;
			status_q  <= o_status;
			aid_q     <= o_aid;
			txid_q    <= o_txid;
			txext_q   <= o_txext;
			txrtr_q   <= o_txrtr;
			txlen_q   <= o_txlen;
			txpay_q   <= o_txpay;
			hint_q    <= o_hint;
			ovf_out_q <= o_ovf;
			last_q    <= o_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ES_IDLE;
			out_valid_q <= 1'b0;
			valid_q     <= '0;
			id_q        <= '0;
			for (int k = 0; k < MAX_JOBS; k++) begin
				ord_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (reg_commit) begin
				id_q <= next_id;
				for (int k = 0; k < MAX_JOBS; k++) begin
					if (valid_q[k]) begin
						ord_q[k] <= ord_q[k] + 1'b1;
					end
				end
				ord_q[free_slot]   <= '0;
				valid_q[free_slot] <= 1'b1;
			end else if (cancel_commit) begin
				for (int k = 0; k < MAX_JOBS; k++) begin
					if (valid_q[k] && (ord_q[k] > age_q)) begin
						ord_q[k] <= ord_q[k] - 1'b1;
					end
				end
				valid_q[slot_q] <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign status      = status_q;
	assign assigned_id = aid_q;
	assign tx_ident    = txid_q;
	assign tx_extended = txext_q;
	assign tx_remote   = txrtr_q;
	assign tx_length   = txlen_q;
	assign tx_payload  = txpay_q;
	assign sleep_hint  = hint_q;
	assign overflow    = ovf_out_q;
	assign last        = last_q;

	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("queue popped while empty");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready)) else $error("result overwritten");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy) else $error("divider restarted while busy");

	a_one_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ES_S_FIND || state_q == ES_C_FIND) |-> $onehot0(match))
		else $error("two jobs share one age");

	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && o_kind == KIND_FRAME) |=> (np_q <= NP_W'(BURST_LIMIT)))
		else $error("burst limit exceeded");

endmodule

>>> hw/rtl/can_periodic_tx_scheduler_core.sv
`timescale 1ns / 1ps
// a cancel walks the jobs newest first; a scan walks every job, runs the
// 48-step remainder divider for each due job and then gives the summary
// a two-item input queue lets commands arrive while the engine works
// reset clears the queue, job valid bits and the id counter; no clearing pass
// ----------------------------------------------------------------------------
// can_periodic_tx_scheduler_core
// Periodic CAN transmit scheduler: job table with register, cancel and scan.
// ----------------------------------------------------------------------------
module can_periodic_tx_scheduler_core #(
	parameter int MAX_JOBS     = cpts_pkg::MAX_JOBS_DEF,
	parameter int BURST_LIMIT  = cpts_pkg::BURST_LIMIT_DEF,
	parameter int SLEEP_CAP_MS = cpts_pkg::SLEEP_CAP_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     cmd,
	input  logic [cpts_pkg::TIME_W-1:0]    current_time_ms,
	input  logic [cpts_pkg::ID_W-1:0]      cancel_id,
	input  logic [cpts_pkg::IDENT_W-1:0]   frame_ident,
	input  logic                           frame_extended,
	input  logic                           frame_remote,
	input  logic [cpts_pkg::LEN_W-1:0]     frame_length,
	input  logic [cpts_pkg::PAY_W-1:0]     frame_payload,
	input  logic [cpts_pkg::PER_W-1:0]     period,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [1:0]                     kind,
	output logic [1:0]                     status,
	output logic [cpts_pkg::ID_W-1:0]      assigned_id,
	output logic [cpts_pkg::IDENT_W-1:0]   tx_ident,
	output logic                           tx_extended,
	output logic                           tx_remote,
	output logic [cpts_pkg::LEN_W-1:0]     tx_length,
	output logic [cpts_pkg::PAY_W-1:0]     tx_payload,
	output logic [cpts_pkg::SLEEP_W-1:0]   sleep_hint,
	output logic                           overflow,
	output logic                           last
);
	import cpts_pkg::*;

	logic     q_valid;
	logic     q_pop;
	job_cmd_t q_head;

	cpts_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (cmd),
		.current_time_ms (current_time_ms),
		.cancel_id       (cancel_id),
		.frame_ident     (frame_ident),
		.frame_extended  (frame_extended),
		.frame_remote    (frame_remote),
		.frame_length    (frame_length),
		.frame_payload   (frame_payload),
		.period          (period),
		.q_valid         (q_valid),
		.q_head          (q_head),
		.q_pop           (q_pop)
	);

	cpts_engine #(
		.MAX_JOBS     (MAX_JOBS),
		.BURST_LIMIT  (BURST_LIMIT),
		.SLEEP_CAP_MS (SLEEP_CAP_MS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.status      (status),
		.assigned_id (assigned_id),
		.tx_ident    (tx_ident),
		.tx_extended (tx_extended),
		.tx_remote   (tx_remote),
		.tx_length   (tx_length),
		.tx_payload  (tx_payload),
		.sleep_hint  (sleep_hint),
		.overflow    (overflow),
		.last        (last)
	);

endmodule

>>> tb/sv/cpts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpts_checker
// Watches both channels of the periodic CAN transmit scheduler, keeps its own
// job table, works out the results each accepted item should give and
// compares every accepted result with the oldest outstanding one.
// ----------------------------------------------------------------------------
module cpts_checker
	import cpts_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  logic [1:0]          cmd,
	input  logic [TIME_W-1:0]   current_time_ms,
	input  logic [ID_W-1:0]     cancel_id,
	input  logic [IDENT_W-1:0]  frame_ident,
	input  logic                frame_extended,
	input  logic                frame_remote,
	input  logic [LEN_W-1:0]    frame_length,
	input  logic [PAY_W-1:0]    frame_payload,
	input  logic [PER_W-1:0]    period,
	input  logic                out_valid,
	input  logic                out_ready,
	input  logic [1:0]          kind,
	input  logic [1:0]          status,
	input  logic [ID_W-1:0]     assigned_id,
	input  logic [IDENT_W-1:0]  tx_ident,
	input  logic                tx_extended,
	input  logic                tx_remote,
	input  logic [LEN_W-1:0]    tx_length,
	input  logic [PAY_W-1:0]    tx_payload,
	input  logic [SLEEP_W-1:0]  sleep_hint,
	input  logic                overflow,
	input  logic                last,
	output int                  fail_count,
	output int                  pending,
	output int                  frames_seen,
	output int                  overflows_seen
);

	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         status;
		logic [ID_W-1:0]    assigned_id;
		logic [IDENT_W-1:0] ident;
		logic               ext;
		logic               rtr;
		logic [LEN_W-1:0]   len;
		logic [PAY_W-1:0]   payload;
		logic [SLEEP_W-1:0] sleep;
		logic               ovf;
		logic               last;
	} sched_result_t;

	typedef struct {
		bit                 used;
		logic [ID_W-1:0]    job_id;
		logic [IDENT_W-1:0] ident;
		logic               ext;
		logic               rtr;
		logic [LEN_W-1:0]   len;
		logic [PAY_W-1:0]   payload;
		logic [PER_W-1:0]   per;
		logic [TIME_W-1:0]  due;
		int                 age;
	} job_t;

	job_t            jobs[MAX_JOBS_DEF];
	logic [ID_W-1:0] next_id;
	sched_result_t   expected_results[$];

	assign pending = expected_results.size();

	function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {17'd0, a} + {1'b0, b};
		return (s > {17'd0, TIME_MAX}) ? TIME_MAX : s[TIME_W-1:0];
	endfunction

	function automatic int slot_by_age(int a);
		for (int i = 0; i < MAX_JOBS_DEF; i++)
			if (jobs[i].used && jobs[i].age == a) return i;
		return -1;
	endfunction

	task automatic predict_item();
		sched_result_t r;
		int            n;
		int            s;
		int            sent;
		bit            ovf;
		logic [63:0]   sleep;
		logic [63:0]   late;
		logic [63:0]   steps;
		logic [63:0]   remain;
		logic [3:0]    l;
		n = 0;
		for (int i = 0; i < MAX_JOBS_DEF; i++) if (jobs[i].used) n++;
		r = '0;
		r.last = 1'b1;
		case (cmd)
			CMD_REGISTER: begin
				r.kind = KIND_REG_ACK;
				s = -1;
				for (int i = MAX_JOBS_DEF - 1; i >= 0; i--) if (!jobs[i].used) s = i;
				if (period == 0) r.status = STAT_INVALID;
				else if (s < 0) r.status = STAT_FULL;
				else begin
					next_id = next_id + 1'b1;
					if (next_id == 0) next_id = 1;
					for (int i = 0; i < MAX_JOBS_DEF; i++) if (jobs[i].used) jobs[i].age++;
					jobs[s].used = 1;
					jobs[s].age = 0;
					jobs[s].job_id = next_id;
					jobs[s].ident = frame_ident;
					jobs[s].ext = frame_extended;
					jobs[s].rtr = frame_remote;
					jobs[s].len = frame_length;
					jobs[s].payload = frame_payload;
					jobs[s].per = period;
					jobs[s].due = sat_add(current_time_ms, {32'd0, period});
					r.assigned_id = next_id;
				end
				expected_results.push_back(r);
			end
			CMD_CANCEL: begin
				r.kind = KIND_CANCEL_ACK;
				r.status = STAT_INVALID;
				if (cancel_id != 0) begin
					for (int a = 0; a < n; a++) begin
						s = slot_by_age(a);
						if (s >= 0 && jobs[s].job_id == cancel_id) begin
							jobs[s].used = 0;
							for (int k = 0; k < MAX_JOBS_DEF; k++)
								if (jobs[k].used && jobs[k].age > a) jobs[k].age--;
							r.status = STAT_OK;
							break;
						end
					end
				end
				expected_results.push_back(r);
			end
			CMD_SCAN: begin
				sent = 0;
				ovf = 0;
				sleep = SLEEP_CAP_DEF;
				for (int a = 0; a < n; a++) begin
					s = slot_by_age(a);
					if (s < 0) continue;
					if (current_time_ms >= jobs[s].due) begin
						if (sent < BURST_LIMIT_DEF) begin
							r = '0;
							r.kind = KIND_FRAME;
							l = (jobs[s].len > MAX_DLC) ? MAX_DLC : jobs[s].len;
							r.ident = jobs[s].ident;
							r.ext = jobs[s].ext;
							r.rtr = jobs[s].rtr;
							r.len = l;
							if (!jobs[s].rtr)
								r.payload = (l >= 8) ? jobs[s].payload :
									jobs[s].payload & ((64'd1 << (l * 8)) - 1);
							expected_results.push_back(r);
							sent++;
						end else ovf = 1;
						late = {16'd0, current_time_ms - jobs[s].due};
						steps = late / jobs[s].per + 1;
						jobs[s].due = sat_add(jobs[s].due, steps * jobs[s].per);
					end
					remain = (jobs[s].due > current_time_ms) ?
						{16'd0, jobs[s].due - current_time_ms} : 0;
					if (remain < sleep) sleep = remain;
				end
				if (ovf) sleep = 0;
				r = '0;
				r.kind = KIND_SUMMARY;
				r.sleep = sleep[SLEEP_W-1:0];
				r.ovf = ovf;
				r.last = 1'b1;
				expected_results.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		sched_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < MAX_JOBS_DEF; i++) jobs[i].used = 0;
			next_id = 0;
			expected_results.delete();
			fail_count = 0;
			frames_seen = 0;
			overflows_seen = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected item kind", kind, 0);
				end else begin
					e = expected_results.pop_front();
					if (kind == KIND_FRAME) frames_seen++;
					if (overflow) overflows_seen++;
					if (kind !== e.kind) report_mismatch("kind", kind, e.kind);
					if (status !== e.status) report_mismatch("status", status, e.status);
					if (assigned_id !== e.assigned_id)
						report_mismatch("assigned_id", assigned_id, e.assigned_id);
					if (tx_ident !== e.ident) report_mismatch("tx_ident", tx_ident, e.ident);
					if (tx_extended !== e.ext) report_mismatch("tx_extended", tx_extended, e.ext);
					if (tx_remote !== e.rtr) report_mismatch("tx_remote", tx_remote, e.rtr);
					if (tx_length !== e.len) report_mismatch("tx_length", tx_length, e.len);
					if (tx_payload !== e.payload)
						report_mismatch("tx_payload", tx_payload, e.payload);
					if (sleep_hint !== e.sleep) report_mismatch("sleep_hint", sleep_hint, e.sleep);
					if (overflow !== e.ovf) report_mismatch("overflow", overflow, e.ovf);
					if (last !== e.last) report_mismatch("last", last, e.last);
				end
			end
			if (in_valid && in_ready) predict_item();
		end
	end

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives register, cancel, scan and unused commands into the periodic CAN transmit
// scheduler with bursty input and a stalling receiver, and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import cpts_pkg::*;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                in_valid = 0;
	logic                in_ready;
	logic [1:0]          cmd = CMD_SCAN;
	logic [TIME_W-1:0]   current_time_ms = 0;
	logic [ID_W-1:0]     cancel_id = 0;
	logic [IDENT_W-1:0]  frame_ident = 0;
	logic                frame_extended = 0;
	logic                frame_remote = 0;
	logic [LEN_W-1:0]    frame_length = 0;
	logic [PAY_W-1:0]    frame_payload = 0;
	logic [PER_W-1:0]    period = 0;
	logic                out_valid;
	logic                out_ready = 0;
	logic [1:0]          kind;
	logic [1:0]          status;
	logic [ID_W-1:0]     assigned_id;
	logic [IDENT_W-1:0]  tx_ident;
	logic                tx_extended;
	logic                tx_remote;
	logic [LEN_W-1:0]    tx_length;
	logic [PAY_W-1:0]    tx_payload;
	logic [SLEEP_W-1:0]  sleep_hint;
	logic                overflow;
	logic                last;
	int                  fail_count;
	int                  pending;
	int                  frames_seen;
	int                  overflows_seen;
	bit                  hold_off = 0;
	logic [TIME_W-1:0]   now_ms = 1000;
	int                  items_sent = 0;

	always #10 clk = ~clk;

	can_periodic_tx_scheduler_core u_top (.*);

	cpts_checker u_checker (.*);

	// receiver stall pattern, with quiet stretches and one long hold-off
	initial begin
		int phase;
		phase = 0;
		forever begin
			@(negedge clk);
			phase++;
			if (hold_off) out_ready <= 0;
			else if ((phase / 200) % 3 == 0) out_ready <= 1;
			else out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// valid stays high after an item so that the next one can follow directly
	task automatic send_item(logic [1:0] c, logic [TIME_W-1:0] t, logic [ID_W-1:0] cid,
			logic [IDENT_W-1:0] id, logic ext, logic rtr, logic [LEN_W-1:0] len,
			logic [PAY_W-1:0] pay, logic [PER_W-1:0] per);
		cmd <= c;
		current_time_ms <= t;
		cancel_id <= cid;
		frame_ident <= id;
		frame_extended <= ext;
		frame_remote <= rtr;
		frame_length <= len;
		frame_payload <= pay;
		period <= per;
		in_valid <= 1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic send_random_item();
		int          pick;
		logic [31:0] per;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 3) == 0) now_ms = now_ms + $urandom_range(0, 40);
		per = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 60);
		if (pick < 40)
			send_item(CMD_REGISTER, now_ms, 0, IDENT_W'($urandom), 1'($urandom),
				1'($urandom), LEN_W'($urandom), {$urandom, $urandom},
				($urandom_range(0, 19) == 0) ? 0 : per);
		else if (pick < 55)
			send_item(CMD_CANCEL, now_ms, ($urandom_range(0, 3) == 0) ? ID_W'($urandom) :
				ID_W'($urandom_range(0, u_checker_ids())), 0, 0, 0, 0, 0, 0);
		else if (pick < 97)
			send_item(CMD_SCAN, now_ms, 0, 0, 0, 0, 0, 0, 0);
		else
			send_item(CMD_UNUSED, TIME_W'($urandom), ID_W'($urandom), 0, 0, 0, 0, 0, 0);
	endtask

	function automatic int u_checker_ids();
		return 200;
	endfunction

	initial begin
		int gap;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		// directed: empty scan, zero period, extremes, remote frames, unknown ids
		send_item(CMD_SCAN, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(CMD_REGISTER, 10, 0, 29'h1FFFFFFF, 1, 0, 15, '1, 0);
		send_item(CMD_REGISTER, 10, 0, 29'h1FFFFFFF, 1, 0, 15, '1, 5);
		send_item(CMD_REGISTER, 10, 0, 0, 0, 1, 8, '1, 3);
		send_item(CMD_REGISTER, 10, 0, 29'h0AAAAAAA, 0, 0, 3, 64'h0123456789ABCDEF, 7);
		send_item(CMD_REGISTER, '1, 0, 5, 1, 1, 0, 64'hFFFF0000FFFF0000, '1);
		send_item(CMD_REGISTER, 10, 0, 6, 0, 0, 0, '1, 1);
		send_item(CMD_SCAN, 12, 0, 0, 0, 0, 0, 0, 0);
		send_item(CMD_SCAN, 100, 0, 0, 0, 0, 0, 0, 0);
		send_item(CMD_SCAN, '1, 0, 0, 0, 0, 0, 0, 0);
		send_item(CMD_CANCEL, 0, 0, 0, 0, 0, 0, 0, 0);
		send_item(CMD_CANCEL, 0, 31'h7FFFFFFF, 0, 0, 0, 0, 0, 0);
		send_item(CMD_CANCEL, 0, 2, 0, 0, 0, 0, 0, 0);
		send_item(CMD_CANCEL, 0, 2, 0, 0, 0, 0, 0, 0);
		send_item(CMD_UNUSED, '1, '1, '1, 1, 1, '1, '1, '1);
		// fill the table, then overflow a scan
		for (int i = 0; i < 34; i++)
			send_item(CMD_REGISTER, 0, 0, IDENT_W'(i), i[0], i[1], i[3:0],
				{$urandom, $urandom}, 2);
		hold_off = 1;
		fork
			begin
				repeat (3000) @(negedge clk);
				hold_off = 0;
			end
			begin
				send_item(CMD_SCAN, 50, 0, 0, 0, 0, 0, 0, 0);
				send_item(CMD_REGISTER, 50, 0, 1, 0, 0, 2, 0, 4);
				send_item(CMD_SCAN, 51, 0, 0, 0, 0, 0, 0, 0);
			end
		join
		for (int i = 1; i <= 40; i++)
			send_item(CMD_CANCEL, 0, ID_W'(i), 0, 0, 0, 0, 0, 0);
		// random part in bursts
		while (items_sent < 300) begin
			repeat ($urandom_range(1, 12)) send_random_item();
			gap = $urandom_range(0, 30);
			if (gap != 0) begin
				in_valid <= 0;
				repeat (gap) @(negedge clk);
			end
		end
		in_valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (2000) @(negedge clk);
		$display("%0d items sent, %0d frames and %0d overflowed scans checked",
			items_sent, frames_seen, overflows_seen);
		if (fail_count == 0 && pending == 0)
			$display("can_periodic_tx_scheduler_core verification clean");
		else
			$display("can_periodic_tx_scheduler_core verification failed");
		$finish;
	end

	initial begin
		#100ms;
		$display("can_periodic_tx_scheduler_core verification failed");
		$finish;
	end

endmodule
